// ===== rtl/mpeg_audio_frame_length_top_assert.svh =====
// assertion macros shared by the frame length pipeline
`ifndef MPEG_AUDIO_FRAME_LENGTH_TOP_ASSERT_SVH
`define MPEG_AUDIO_FRAME_LENGTH_TOP_ASSERT_SVH

// same-cycle implication
`define MAFL_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mpeg audio frame length: implication failed");

// next-cycle implication
`define MAFL_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mpeg audio frame length: next-cycle check failed");

`endif

// ===== rtl/mafl_pkg.sv =====
// shared types, codes and tables of the frame length pipeline
`default_nettype none

package mafl_pkg;

   localparam logic [7:0] SYNC_BYTE = 8'hff;
   localparam logic [2:0] SYNC_TAIL = 3'b111;
   localparam logic [1:0] EMPH_RSVD = 2'd2;

   localparam logic [1:0] VER_25   = 2'd0;
   localparam logic [1:0] VER_RSVD = 2'd1;
   localparam logic [1:0] VER_2    = 2'd2;
   localparam logic [1:0] VER_1    = 2'd3;

   localparam logic [1:0] LAYER_RSVD = 2'd0;
   localparam logic [1:0] LAYER_3    = 2'd1;
   localparam logic [1:0] LAYER_2    = 2'd2;
   localparam logic [1:0] LAYER_1    = 2'd3;

   localparam logic [3:0] BRI_FREE = 4'd0;
   localparam logic [3:0] BRI_BAD  = 4'd15;
   localparam logic [1:0] SRI_RSVD = 2'd3;

   localparam logic [2:0] ROW_V1_L1 = 3'd0;
   localparam logic [2:0] ROW_V1_L2 = 3'd1;
   localparam logic [2:0] ROW_V1_L3 = 3'd2;
   localparam logic [2:0] ROW_V2_L1 = 3'd3;
   localparam logic [2:0] ROW_V2_LX = 3'd4;

   // samples factor divided by twelve
   localparam logic [3:0] UNIT_L1    = 4'd1;
   localparam logic [3:0] UNIT_FULL  = 4'd12;
   localparam logic [3:0] UNIT_HALF  = 4'd6;

   // ceil(2^32 / 441), exact floor for dividends below 2^32 / 59
   localparam int         RECIP_SHIFT = 32;
   localparam logic [23:0] RECIP_441  = 24'd9739155;

   localparam int PROD_W = 13;
   localparam int NUM_W  = 22;
   localparam int QUO_W  = 14;
   localparam int LEN_W  = 12;
   localparam int WIDE_W = NUM_W + 24;

   typedef enum logic [1:0] {
      HZ_BASE_11025,
      HZ_BASE_12000,
      HZ_BASE_8000
   } hz_base_type;

   typedef struct packed {
      logic        ok;
      logic [3:0]  unit;
      logic [8:0]  rate;
      hz_base_type base;
      logic [1:0]  shift;
      logic        pad;
      logic        layer1;
   } hdr_type;

   typedef struct packed {
      logic             ok;
      logic [QUO_W-1:0] quo;
      logic [1:0]       shift;
      logic             pad;
      logic             layer1;
   } quo_res_type;

   // bitrate in kbit/s by table row and bitrate index
   localparam logic [8:0] RATE_TAB [0:7][0:15] = '{
      '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256,
        9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0},
      '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112, 9'd128,
        9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0},
      '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
        9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0},
      '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112, 9'd128,
        9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0},
      '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64,
        9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0},
      '{16{9'd0}},
      '{16{9'd0}},
      '{16{9'd0}}
   };

endpackage

`default_nettype wire

// ===== rtl/mpeg_audio_frame_length_top.sv =====
// mpeg audio frame header check and frame length pipeline
//
//   channel  dir  ports                       contents
//   req_     in   valid, ready, header_word   one 32-bit frame header
//   rsp_     out  valid, ready, header_ok,    valid flag and frame length in bytes
//                 frame_length
//
// one transaction per cycle while rsp_ready stays high
// stages: field decode and bitrate table, factor product, divisor scaling, reciprocal
// multiply by 1/441 for the 11025 Hz base, shift plus padding to the output register
// reset clears every stage valid bit; no state survives between headers
// each stage stalls only when it holds data and the next stage is full,
// so bubbles are filled while a result waits on rsp_ready
`default_nettype none
`include "mpeg_audio_frame_length_top_assert.svh"

module mpeg_audio_frame_length_top
   import mafl_pkg::*;
(
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire logic [31:0]      req_header_word,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic                  rsp_header_ok,
   output logic [LEN_W-1:0]      rsp_frame_length
);

   logic              dec_valid;
   logic              dec_ready;
   hdr_type           dec_hdr;
   logic              div_valid;
   logic              div_ready;
   quo_res_type       div_res;

   logic              valid_ff;
   logic              ok_ff;
   logic              ok_in;
   logic [LEN_W-1:0]  len_ff;
   logic [LEN_W-1:0]  len_in;
   logic [QUO_W-1:0]  len_raw;
   logic [LEN_W-1:0]  len_scaled;
   logic              en;

   mafl_decode u_decode (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_valid),
      .in_ready    (req_ready),
      .header_word (req_header_word),
      .out_valid   (dec_valid),
      .out_ready   (dec_ready),
      .out_hdr     (dec_hdr)
   );

   mafl_divide u_divide (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (dec_valid),
      .in_ready  (dec_ready),
      .in_hdr    (dec_hdr),
      .out_valid (div_valid),
      .out_ready (div_ready),
      .out_res   (div_res)
   );

   assign en        = !valid_ff || rsp_ready;
   assign div_ready = en;

   assign len_raw    = (div_res.quo >> div_res.shift) + QUO_W'(div_res.pad);
   assign len_scaled = div_res.layer1 ? {len_raw[LEN_W-3:0], 2'b00} : len_raw[LEN_W-1:0];
   assign ok_in      = div_res.ok && (len_scaled != '0);
   assign len_in     = ok_in ? len_scaled : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en && div_valid) begin
         ok_ff  <= ok_in;
         len_ff <= len_in;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_header_ok    = ok_ff;
   assign rsp_frame_length = len_ff;

   `MAFL_ASSERT_NEXT(a_top_take, clock, reset, div_valid && en, valid_ff)
   `MAFL_ASSERT_IMPLY(a_top_len, clock, reset, valid_ff, ok_ff == (len_ff != '0))
   `MAFL_ASSERT_NEXT(a_top_l1, clock, reset,
      div_valid && en && div_res.layer1, len_ff[1:0] == 2'b00)

endmodule

`default_nettype wire

// ===== rtl/mafl_decode.sv =====
// header field check and table lookup stage
`default_nettype none
`include "mpeg_audio_frame_length_top_assert.svh"

module mafl_decode
   import mafl_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        in_valid,
   output logic             in_ready,
   input  wire logic [31:0] header_word,
   output logic             out_valid,
   input  wire logic        out_ready,
   output hdr_type          out_hdr
);

   logic       valid_ff;
   hdr_type    hdr_ff;
   hdr_type    hdr_in;
   logic       en;
   logic [1:0] ver;
   logic [1:0] lay;
   logic [3:0] bri;
   logic [1:0] sri;
   logic [2:0] row;
   logic [1:0] log_m;
   logic       sync_ok;

   assign en       = !valid_ff || out_ready;
   assign in_ready = en;

   assign ver = header_word[20:19];
   assign lay = header_word[18:17];
   assign bri = header_word[15:12];
   assign sri = header_word[11:10];
   assign sync_ok = (header_word[31:24] == SYNC_BYTE) && (header_word[23:21] == SYNC_TAIL);

   always_comb begin
      row       = ROW_V2_LX;
      log_m     = 2'd0;
      hdr_in    = '0;
      hdr_in.pad    = header_word[9];
      hdr_in.layer1 = (lay == LAYER_1);
      case (ver)
         VER_1: begin
            log_m = 2'd2;
            case (lay)
               LAYER_1: row = ROW_V1_L1;
               LAYER_2: row = ROW_V1_L2;
               default: row = ROW_V1_L3;
            endcase
         end
         VER_2: begin
            log_m = 2'd1;
            row   = (lay == LAYER_1) ? ROW_V2_L1 : ROW_V2_LX;
         end
         default: begin
            log_m = 2'd0;
            row   = (lay == LAYER_1) ? ROW_V2_L1 : ROW_V2_LX;
         end
      endcase
      case (lay)
         LAYER_1: hdr_in.unit = UNIT_L1;
         LAYER_2: hdr_in.unit = UNIT_FULL;
         default: hdr_in.unit = (ver == VER_1) ? UNIT_FULL : UNIT_HALF;
      endcase
      case (sri)
         2'd0:    hdr_in.base = HZ_BASE_11025;
         2'd1:    hdr_in.base = HZ_BASE_12000;
         default: hdr_in.base = HZ_BASE_8000;
      endcase
      hdr_in.shift = log_m + ((sri == 2'd2) ? 2'd1 : 2'd0);
      hdr_in.rate  = RATE_TAB[row][bri];
      hdr_in.ok    = sync_ok && (header_word[1:0] != EMPH_RSVD) && (ver != VER_RSVD)
                     && (lay != LAYER_RSVD) && !(bri inside {BRI_FREE, BRI_BAD})
                     && (sri != SRI_RSVD);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en && in_valid) begin
         hdr_ff <= hdr_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_hdr   = hdr_ff;

   `MAFL_ASSERT_NEXT(a_dec_hold, clock, reset, valid_ff && !out_ready, valid_ff && $stable(hdr_ff))
   `MAFL_ASSERT_IMPLY(a_dec_ready, clock, reset, !valid_ff, in_ready)
   `MAFL_ASSERT_NEXT(a_dec_take, clock, reset, in_valid && in_ready, valid_ff)

endmodule

`default_nettype wire

// ===== rtl/mafl_divide.sv =====
// product, scaling and divide-by-441 stages
`default_nettype none
`include "mpeg_audio_frame_length_top_assert.svh"

module mafl_divide
   import mafl_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  in_valid,
   output logic       in_ready,
   input  wire hdr_type in_hdr,
   output logic       out_valid,
   input  wire logic  out_ready,
   output quo_res_type out_res
);

   // stage 2: bitrate times factor over twelve
   logic              v2_ff;
   logic [PROD_W-1:0] p_ff;
   logic [PROD_W-1:0] p_in;
   hdr_type           h2_ff;
   logic              en2;

   // stage 3: numerator for the chosen divisor
   logic              v3_ff;
   logic [NUM_W-1:0]  a_ff;
   logic [NUM_W-1:0]  a_in;
   hdr_type           h3_ff;
   logic              en3;

   // stage 4: quotient
   logic              v4_ff;
   logic [QUO_W-1:0]  q_ff;
   logic [QUO_W-1:0]  q_in;
   logic [WIDE_W-1:0] wide;
   hdr_type           h4_ff;
   logic              en4;

   assign en4      = !v4_ff || out_ready;
   assign en3      = !v3_ff || en4;
   assign en2      = !v2_ff || en3;
   assign in_ready = en2;

   assign p_in = PROD_W'({9'd0, in_hdr.unit} * {4'd0, in_hdr.rate});

   always_comb begin
      case (h2_ff.base)
         HZ_BASE_11025: a_in = {p_ff, 9'd0} - {4'd0, p_ff, 5'd0};
         HZ_BASE_8000:  a_in = NUM_W'(p_ff) + NUM_W'({p_ff, 1'b0});
         default:       a_in = NUM_W'(p_ff);
      endcase
   end

   assign wide = WIDE_W'(a_ff) * WIDE_W'(RECIP_441);
   assign q_in = (h3_ff.base == HZ_BASE_11025) ? wide[RECIP_SHIFT +: QUO_W] : a_ff[QUO_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en2) begin
            v2_ff <= in_valid;
         end
         if (en3) begin
            v3_ff <= v2_ff;
         end
         if (en4) begin
            v4_ff <= v3_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en2 && in_valid) begin
         p_ff  <= p_in;
         h2_ff <= in_hdr;
      end
      if (en3 && v2_ff) begin
         a_ff  <= a_in;
         h3_ff <= h2_ff;
      end
      if (en4 && v3_ff) begin
         q_ff  <= q_in;
         h4_ff <= h3_ff;
      end
   end

   assign out_valid      = v4_ff;
   assign out_res.ok     = h4_ff.ok;
   assign out_res.quo    = q_ff;
   assign out_res.shift  = h4_ff.shift;
   assign out_res.pad    = h4_ff.pad;
   assign out_res.layer1 = h4_ff.layer1;

   `MAFL_ASSERT_NEXT(a_div_hold, clock, reset, v4_ff && !out_ready, v4_ff && $stable(q_ff))
   `MAFL_ASSERT_NEXT(a_div_pass, clock, reset,
      v3_ff && en4 && (h3_ff.base == HZ_BASE_12000), q_ff == $past(a_ff[QUO_W-1:0]))
   `MAFL_ASSERT_NEXT(a_div_keep, clock, reset, v2_ff && !en3, v2_ff && $stable(p_ff))

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// self-checking testbench for the mpeg audio frame header length pipeline
`timescale 1ns / 1ps

module tb_top;
   import mafl_pkg::*;

   typedef struct {
      logic             ok;
      logic [LEN_W-1:0] len;
   } frame_result_type;

   typedef struct {
      logic [31:0]      header;
      bit               typed;
      frame_result_type result;
   } header_row_type;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int RANDOM_HEADERS = 1100;
   localparam int DRAIN_CYCLES   = 20;
   localparam int HOLD_AT        = 300;
   localparam int HOLD_CYCLES    = 80;
   localparam int STEADY_FROM    = 400;
   localparam int STEADY_TO      = 650;
   localparam int PAUSE_AT       = 800;

   // kbit/s for bitrate index 1..14
   localparam int unsigned KBPS [0:4][1:14] = '{
      '{32, 64, 96, 128, 160, 192, 224, 256, 288, 320, 352, 384, 416, 448},
      '{32, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320, 384},
      '{32, 40, 48, 56, 64, 80, 96, 112, 128, 160, 192, 224, 256, 320},
      '{32, 48, 56, 64, 80, 96, 112, 128, 144, 160, 176, 192, 224, 256},
      '{8, 16, 24, 32, 40, 48, 56, 64, 80, 96, 112, 128, 144, 160}
   };
   localparam int unsigned MPEG1_HZ [0:2] = '{44100, 48000, 32000};

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   logic [31:0]      req_header_word;
   logic             rsp_valid;
   logic             rsp_ready;
   logic             rsp_header_ok;
   logic [LEN_W-1:0] rsp_frame_length;

   frame_result_type expected_frames[$];
   int               headers_accepted;
   int               frames_seen;
   int               mismatches;
   int               stalled_cycles;

   mpeg_audio_frame_length_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_header_word  (req_header_word),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_header_ok    (rsp_header_ok),
      .rsp_frame_length (rsp_frame_length)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      clock           = 1'b0;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_header_word = '0;
      rsp_ready       = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
   end

   function automatic frame_result_type predict_frame(input logic [31:0] w);
      frame_result_type r;
      logic [1:0]    ver;
      logic [1:0]    lay;
      logic [3:0]    bri;
      logic [1:0]    sri;
      int unsigned   row;
      int unsigned   factor;
      int unsigned   hz;
      int unsigned   len;
      r.ok  = 1'b0;
      r.len = '0;
      ver = w[20:19];
      lay = w[18:17];
      bri = w[15:12];
      sri = w[11:10];
      if (w[31:24] != SYNC_BYTE || w[23:21] != SYNC_TAIL || w[1:0] == EMPH_RSVD)
         return r;
      if (ver == VER_RSVD || lay == LAYER_RSVD || bri == BRI_FREE || bri == BRI_BAD ||
          sri == SRI_RSVD)
         return r;
      if (ver == VER_1) begin
         row    = (lay == LAYER_1) ? ROW_V1_L1 : (lay == LAYER_2) ? ROW_V1_L2 : ROW_V1_L3;
         factor = (lay == LAYER_1) ? 12 : 144;
         hz     = MPEG1_HZ[sri];
      end else begin
         row    = (lay == LAYER_1) ? ROW_V2_L1 : ROW_V2_LX;
         factor = (lay == LAYER_1) ? 12 : (lay == LAYER_2) ? 144 : 72;
         hz     = MPEG1_HZ[sri] >> ((ver == VER_2) ? 1 : 2);
      end
      len = factor * KBPS[row][bri] * 1000 / hz + w[9];
      if (lay == LAYER_1)
         len = len * 4;
      if (len == 0)
         return r;
      r.ok  = 1'b1;
      r.len = len[LEN_W-1:0];
      return r;
   endfunction

   // ignored bits come from junk
   function automatic logic [31:0] make_header(input logic [1:0] ver, input logic [1:0] lay,
                                               input logic [3:0] bri, input logic [1:0] sri,
                                               input logic pad, input logic [1:0] emph,
                                               input logic [31:0] junk);
      return {SYNC_BYTE, SYNC_TAIL, ver, lay, junk[16], bri, sri, pad, junk[8:2], emph};
   endfunction

   function automatic logic [31:0] random_good_header();
      logic [1:0] ver;
      logic [1:0] emph;
      case ($urandom_range(2))
         0:       ver = VER_25;
         1:       ver = VER_2;
         default: ver = VER_1;
      endcase
      emph = 2'($urandom_range(3));
      if (emph == EMPH_RSVD)
         emph = ~EMPH_RSVD;
      return make_header(ver, 2'($urandom_range(LAYER_1, LAYER_3)),
                         4'($urandom_range(14, 1)), 2'($urandom_range(2)),
                         1'($urandom_range(1)), emph, $urandom);
   endfunction

   function automatic logic [31:0] random_header();
      logic [31:0] w;
      int          pick;
      pick = $urandom_range(99);
      w    = random_good_header();
      if (pick >= 88)
         return $urandom;
      if (pick >= 75) begin
         case ($urandom_range(6))
            0:       w[31:24] = 8'($urandom_range(254));
            1:       w[23:21] = 3'($urandom_range(6));
            2:       w[1:0]   = EMPH_RSVD;
            3:       w[20:19] = VER_RSVD;
            4:       w[18:17] = LAYER_RSVD;
            5:       w[15:12] = $urandom_range(1) ? BRI_FREE : BRI_BAD;
            default: w[11:10] = SRI_RSVD;
         endcase
      end
      return w;
   endfunction

   task automatic offer_header(input logic [31:0] w, input frame_result_type exp_frame,
                               input bit steady);
      while (!steady && $urandom_range(99) < 37) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_header_word <= w;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      expected_frames.push_back(exp_frame);
      @(negedge clock);
   endtask

   function automatic header_row_type typed_row(input logic [31:0] w, input logic ok,
                                                input int len);
      header_row_type row;
      row.header     = w;
      row.typed      = 1'b1;
      row.result.ok  = ok;
      row.result.len = LEN_W'(len);
      return row;
   endfunction

   function automatic header_row_type open_row(input logic [31:0] w);
      header_row_type row;
      row.header = w;
      row.typed  = 1'b0;
      row.result = predict_frame(w);
      return row;
   endfunction

   // sender
   initial begin
      header_row_type rows[$];
      logic [31:0]    w;
      logic [1:0]     vers[3];
      vers = '{VER_25, VER_2, VER_1};
      w    = make_header(VER_1, LAYER_3, 4'd9, 2'd0, 1'b0, 2'd0, '0);
      rows.push_back(typed_row(32'h0000_0000, 1'b0, 0));
      rows.push_back(typed_row(32'hffff_ffff, 1'b0, 0));
      rows.push_back(typed_row(w & 32'h7fff_ffff, 1'b0, 0));
      rows.push_back(typed_row(w & ~32'h0020_0000, 1'b0, 0));
      rows.push_back(typed_row({w[31:2], EMPH_RSVD}, 1'b0, 0));
      rows.push_back(typed_row({w[31:21], VER_RSVD, w[18:0]}, 1'b0, 0));
      rows.push_back(typed_row({w[31:19], LAYER_RSVD, w[16:0]}, 1'b0, 0));
      rows.push_back(typed_row({w[31:16], BRI_FREE, w[11:0]}, 1'b0, 0));
      rows.push_back(typed_row({w[31:16], BRI_BAD, w[11:0]}, 1'b0, 0));
      rows.push_back(typed_row({w[31:12], SRI_RSVD, w[9:0]}, 1'b0, 0));
      rows.push_back(typed_row(w, 1'b1, 417));
      rows.push_back(typed_row(make_header(VER_1, LAYER_1, 4'd14, 2'd2, 1'b1, 2'd3, '1),
                               1'b1, 676));
      rows.push_back(typed_row(make_header(VER_25, LAYER_2, 4'd14, 2'd2, 1'b1, 2'd1, '1),
                               1'b1, 2881));
      rows.push_back(typed_row(make_header(VER_25, LAYER_3, 4'd1, 2'd1, 1'b0, 2'd0, '0),
                               1'b1, 48));
      rows.push_back(typed_row(make_header(VER_1, LAYER_1, 4'd1, 2'd1, 1'b0, 2'd0, '0),
                               1'b1, 32));
      foreach (vers[i])
         for (int lay = LAYER_3; lay <= LAYER_1; lay++)
            rows.push_back(open_row(make_header(vers[i], 2'(lay),
                                                4'($urandom_range(14, 1)),
                                                2'($urandom_range(2)),
                                                1'($urandom_range(1)),
                                                $urandom_range(1) ? 2'd1 : 2'd3, $urandom)));

      @(negedge clock);
      while (reset)
         @(negedge clock);
      foreach (rows[i])
         offer_header(rows[i].header, rows[i].result, 1'b0);
      for (int n = 0; n < RANDOM_HEADERS; n++) begin
         if (n == PAUSE_AT) begin
            req_valid <= 1'b0;
            while (expected_frames.size() != 0)
               @(negedge clock);
         end
         w = random_header();
         offer_header(w, predict_frame(w), n >= STEADY_FROM && n < STEADY_TO);
      end
      req_valid <= 1'b0;

      while (expected_frames.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   // receiver
   initial begin
      int  hold;
      bit  held;
      hold = 0;
      held = 1'b0;
      @(negedge clock);
      while (reset)
         @(negedge clock);
      forever begin
         if (!held && headers_accepted >= HOLD_AT) begin
            held = 1'b1;
            hold = HOLD_CYCLES;
         end
         if (hold > 0) begin
            hold--;
            rsp_ready <= 1'b0;
         end else if (headers_accepted >= STEADY_FROM && headers_accepted < STEADY_TO) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= ($urandom_range(99) >= 37);
         end
         @(negedge clock);
      end
   end

   // result check and watchdog
   always @(posedge clock) begin
      frame_result_type exp_frame;
      if (reset) begin
         headers_accepted <= 0;
         frames_seen      <= 0;
         mismatches       <= 0;
         stalled_cycles   <= 0;
      end else begin
         if (req_valid && req_ready)
            headers_accepted <= headers_accepted + 1;
         if (rsp_valid && rsp_ready) begin
            frames_seen <= frames_seen + 1;
            if (expected_frames.size() == 0) begin
               if (mismatches < 10)
                  $display("unexpected transaction: ok %0b len %0d",
                           rsp_header_ok, rsp_frame_length);
               mismatches <= mismatches + 1;
            end else begin
               exp_frame = expected_frames.pop_front();
               if (rsp_header_ok !== exp_frame.ok || rsp_frame_length !== exp_frame.len) begin
                  if (mismatches < 10)
                     $display("mismatch at transaction %0d: expected ok %0b len %0d, %s",
                              frames_seen, exp_frame.ok, exp_frame.len,
                              $sformatf("got ok %0b len %0d", rsp_header_ok,
                                        rsp_frame_length));
                  mismatches <= mismatches + 1;
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            stalled_cycles <= 0;
         else
            stalled_cycles <= stalled_cycles + 1;
         if (stalled_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

endmodule
